FILE: src/csg_pkg.sv
package csg_pkg;

  localparam int COUNTS_PER_REV = 1600;
  localparam int CNT_W          = 11;
  localparam int TURNS_W        = 32;
  localparam int LEAD_W         = 13;
  localparam int LIM_W          = 9;
  localparam int IN_DATA_W      = 72;
  localparam int OUT_DATA_W     = 8;

  localparam logic [CNT_W-1:0] CPR_M1 = CNT_W'(COUNTS_PER_REV - 1);
  localparam logic signed [LEAD_W-1:0] CPR_L  = LEAD_W'(COUNTS_PER_REV);
  localparam logic signed [LEAD_W-1:0] HALF_L = LEAD_W'(COUNTS_PER_REV / 2);

  // pending step: -1, 0 or +1
  typedef logic signed [1:0] delta_t;
  localparam delta_t DELTA_DOWN = -2'sd1;
  localparam delta_t DELTA_NONE = 2'sd0;
  localparam delta_t DELTA_UP   = 2'sd1;

  typedef struct packed {
    logic step;
    logic direction;
  } lane_res_t;

endpackage

FILE: src/csg_lane.sv
module csg_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [csg_pkg::LIM_W-1:0]     max_lead,
  input  logic [csg_pkg::TURNS_W-1:0]   target_turns,
  input  logic [csg_pkg::CNT_W-1:0]     target_count,
  input  logic [csg_pkg::CNT_W-1:0]     encoder,
  output csg_pkg::lane_res_t            res
);
  import csg_pkg::*;

  delta_t             delta, delta_next;
  logic [TURNS_W-1:0] pulse_turns, pulse_turns_next;
  logic [CNT_W-1:0]   pulse_count, pulse_count_next;
  logic               dir_latch, dir_latch_next;

  logic signed [TURNS_W:0]  dt;
  logic                     dt_zero, dt_m1, dt_pos, dt_lt_m1;
  logic signed [LEAD_W-1:0] cmp0, cmp1, lead_raw, lead, lim;
  logic                     dist_pos, dist_neg;
  delta_t                   pick;

  assign dt = $signed({target_turns[TURNS_W-1], target_turns})
            - $signed({pulse_turns[TURNS_W-1], pulse_turns});
  assign dt_zero  = (dt == '0);
  assign dt_m1    = (dt == -(TURNS_W+1)'(1));
  assign dt_pos   = !dt[TURNS_W] && !dt_zero;
  assign dt_lt_m1 = dt[TURNS_W] && !dt_m1;

  // turn difference of zero or minus one: the count part decides the sign
  assign cmp0 = $signed({2'b00, target_count}) - $signed({2'b00, pulse_count});
  assign cmp1 = cmp0 - CPR_L;

  assign dist_pos = dt_pos || (dt_zero && cmp0 > 0) || (dt_m1 && cmp1 > 0);
  assign dist_neg = dt_lt_m1 || (dt_zero && cmp0 < 0) || (dt_m1 && cmp1 < 0);

  assign lead_raw = $signed({2'b00, pulse_count}) - $signed({2'b00, encoder});
  assign lim      = $signed({{(LEAD_W-LIM_W){1'b0}}, max_lead});

  always_comb begin
    if (lead_raw >= HALF_L) begin
      lead = lead_raw - CPR_L;
    end else if (lead_raw < -HALF_L) begin
      lead = lead_raw + CPR_L;
    end else begin
      lead = lead_raw;
    end
  end

  always_comb begin
    if (dist_neg) begin
      if (lead > -lim)       pick = DELTA_DOWN;
      else if (lead == -lim) pick = DELTA_NONE;
      else                   pick = DELTA_UP;
    end else if (dist_pos) begin
      if (lead < lim)        pick = DELTA_UP;
      else if (lead == lim)  pick = DELTA_NONE;
      else                   pick = DELTA_DOWN;
    end else begin
      if (lead < -lim)       pick = DELTA_UP;
      else if (lead > lim)   pick = DELTA_DOWN;
      else                   pick = DELTA_NONE;
    end
  end

  always_comb begin
    delta_next       = delta;
    pulse_turns_next = pulse_turns;
    pulse_count_next = pulse_count;
    dir_latch_next   = dir_latch;
    if (delta == DELTA_NONE) begin
      delta_next = pick;
      if (pick == DELTA_DOWN)    dir_latch_next = 1'b0;
      else if (pick == DELTA_UP) dir_latch_next = 1'b1;
    end else begin
      delta_next = DELTA_NONE;
      if (delta == DELTA_DOWN) begin
        if (pulse_count != '0) begin
          pulse_count_next = pulse_count - CNT_W'(1);
        end else begin
          pulse_count_next = CPR_M1;
          pulse_turns_next = pulse_turns - TURNS_W'(1);
        end
      end else begin
        if (pulse_count < CPR_M1) begin
          pulse_count_next = pulse_count + CNT_W'(1);
        end else begin
          pulse_count_next = '0;
          pulse_turns_next = pulse_turns + TURNS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delta       <= DELTA_NONE;
      pulse_turns <= '0;
      pulse_count <= '0;
      dir_latch   <= 1'b0;
    end else if (accept) begin
      delta       <= delta_next;
      pulse_turns <= pulse_turns_next;
      pulse_count <= pulse_count_next;
      dir_latch   <= dir_latch_next;
    end
  end

  assign res.step      = (delta != DELTA_NONE);
  assign res.direction = dir_latch_next;

endmodule

FILE: src/csg_out.sv
module csg_out (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  csg_pkg::lane_res_t              odd_res,
  input  csg_pkg::lane_res_t              even_res,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [csg_pkg::OUT_DATA_W-1:0]  out_data
);
  import csg_pkg::*;

  logic [3:0] word;
  logic [3:0] main_data, spare_data;
  logic       main_valid, spare_valid;
  logic       pop;

  // merge lanes: odd step, odd dir, even step, even dir from bit 0 up
  assign word = {even_res.direction, even_res.step, odd_res.direction, odd_res.step};
  assign pop  = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      main_valid  <= spare_valid || push;
      spare_valid <= 1'b0;
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= spare_valid ? spare_data : word;
    end else if (push) begin
      spare_data <= word;
    end
  end

  assign in_ready  = !spare_valid;
  assign out_valid = main_valid;
  assign out_data  = {{(OUT_DATA_W-4){1'b0}}, main_data};

endmodule

FILE: src/closed_loop_stepper_step_gen.sv
// Step/direction generator for two closed-loop stepper motors.
// Slave stream: one word per tick carrying the shared target position
// (turns and count) and the encoder count of each motor. Master stream:
// one word per accepted tick with step level and direction per motor.
// max_lead is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block does not enforce it; resets to 8.
// Each motor has its own lane holding pulse position, pending step and
// direction latch; both lanes decide and update in the cycle a word is
// accepted, so a new word is taken every cycle while s_axis_tready is high.
// The result passes through the output buffer registers to the master side.
// Throughput: one word per cycle, limited only by the two-entry output
// buffer; s_axis_tready drops once both entries hold words the receiver
// has not taken, and the lanes hold their state meanwhile.
// Reset (rst, synchronous) clears pulse positions, pending steps,
// direction latches and the output buffer.
module closed_loop_stepper_step_gen (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [csg_pkg::LIM_W-1:0]       cfg_wdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // target_turns[31:0], target_count[42:32], odd_encoder[53:43],
  // even_encoder[64:54], zero fill above
  input  logic [csg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // odd_step[0], odd_direction[1], even_step[2], even_direction[3], zero fill
  output logic [csg_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import csg_pkg::*;

  logic [LIM_W-1:0]   max_lead;
  logic               accept;
  logic [TURNS_W-1:0] target_turns;
  logic [CNT_W-1:0]   target_count, odd_encoder, even_encoder;
  lane_res_t          odd_res, even_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lead <= LIM_W'(8);
    end else if (cfg_we) begin
      max_lead <= cfg_wdata;
    end
  end

  assign target_turns = s_axis_tdata[TURNS_W-1:0];
  assign target_count = s_axis_tdata[TURNS_W +: CNT_W];
  assign odd_encoder  = s_axis_tdata[TURNS_W+CNT_W +: CNT_W];
  assign even_encoder = s_axis_tdata[TURNS_W+2*CNT_W +: CNT_W];

  assign accept = s_axis_tvalid && s_axis_tready;

  csg_lane u_odd (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .max_lead     (max_lead),
    .target_turns (target_turns),
    .target_count (target_count),
    .encoder      (odd_encoder),
    .res          (odd_res)
  );

  csg_lane u_even (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .max_lead     (max_lead),
    .target_turns (target_turns),
    .target_count (target_count),
    .encoder      (even_encoder),
    .res          (even_res)
  );

  csg_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .odd_res   (odd_res),
    .even_res  (even_res),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
